// ----- hw/rtl/aag_pkg.sv -----
// Shared types, codes and helpers for the auxiliary address generator.
`timescale 1ns / 1ps
package aag_pkg;

  localparam logic [1:0] KIND_SINGLE = 2'd0;
  localparam logic [1:0] KIND_LONG   = 2'd1;
  localparam logic [1:0] KIND_XMEM   = 2'd2;
  localparam logic [1:0] KIND_LOAD   = 2'd3;

  localparam logic [3:0] MODE_NONE     = 4'd0;
  localparam logic [3:0] MODE_POST_DEC = 4'd1;
  localparam logic [3:0] MODE_POST_INC = 4'd2;
  localparam logic [3:0] MODE_PRE_INC  = 4'd3;
  localparam logic [3:0] MODE_RC_SUB   = 4'd4;
  localparam logic [3:0] MODE_SUB_AR0  = 4'd5;
  localparam logic [3:0] MODE_ADD_AR0  = 4'd6;
  localparam logic [3:0] MODE_RC_ADD   = 4'd7;
  localparam logic [3:0] MODE_CIRC_DEC = 4'd8;
  localparam logic [3:0] MODE_CIRC_SUB = 4'd9;
  localparam logic [3:0] MODE_CIRC_INC = 4'd10;
  localparam logic [3:0] MODE_CIRC_ADD = 4'd11;
  localparam logic [3:0] MODE_IMM_OFS  = 4'd12;
  localparam logic [3:0] MODE_IMM_PRE  = 4'd13;
  localparam logic [3:0] MODE_IMM_CIRC = 4'd14;
  localparam logic [3:0] MODE_ABS      = 4'd15;

  localparam logic [1:0] XMOD_NONE = 2'd0;
  localparam logic [1:0] XMOD_DEC  = 2'd1;
  localparam logic [1:0] XMOD_INC  = 2'd2;
  localparam logic [1:0] XMOD_CIRC = 2'd3;

  localparam logic [3:0] REM_LAST_STEP = 4'd15;
  localparam logic [2:0] XMEM_AR_BASE  = 3'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  opcode_low;
    logic [15:0] long_imm;
    logic [8:0]  dp_page;
    logic [15:0] stack_ptr;
    logic        cpl_mode;
    logic        compat_mode;
    logic [15:0] circ_size;
    logic [2:0]  ar_index;
    logic [15:0] ar_value;
  } aag_in_t;

  typedef struct packed {
    logic [15:0] address;
    logic        indirect;
    logic        used_long_imm;
    logic        arp_write;
    logic [2:0]  arp_value;
  } aag_out_t;

  typedef struct packed {
    logic [2:0]  ar_idx;
    logic        ar_we;
    logic        circ;
    logic        step_neg;
    logic [15:0] step_mag;
    logic [15:0] lin_ar;
    logic [15:0] addr;
    logic        addr_new;
    logic        indirect;
    logic        used_long_imm;
    logic        arp_write;
    logic [2:0]  arp_value;
  } aag_dec_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_REM_AR,
    S_WAIT_AR,
    S_REM_STEP,
    S_WAIT_STEP,
    S_COMBINE,
    S_DONE
  } aag_state_e;

  function automatic logic [2:0] ar_sel(input logic [1:0] kind, input logic [7:0] opcode);
    if (kind == KIND_XMEM) begin
      return {1'b0, opcode[5:4]} + XMEM_AR_BASE;
    end
    return opcode[2:0];
  endfunction

endpackage

// ----- hw/rtl/aag_rem_unit.sv -----
// Iterative 16-bit restoring remainder unit, one quotient bit per cycle.
`timescale 1ns / 1ps
module aag_rem_unit import aag_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [15:0] dividend_i,
  input  logic [15:0] divisor_i,
  output logic        busy_o,
  output logic        done_o,
  output logic [15:0] rem_o
);

  logic        busy_q;
  logic        done_q;
  logic [3:0]  cnt_q;
  logic [15:0] dvd_q;
  logic [15:0] div_q;
  logic [15:0] rem_q;
  logic [15:0] rem_d;
  logic [16:0] trial;

  always_comb begin
    trial = {rem_q, dvd_q[15]};
    if (trial >= {1'b0, div_q}) begin
      rem_d = 16'(trial - {1'b0, div_q});
    end else begin
      rem_d = trial[15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 4'd1;
        if (cnt_q == REM_LAST_STEP) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      div_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[14:0], 1'b0};
      rem_q <= rem_d;
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

// ----- hw/rtl/aag_decode.sv -----
// Operand decode: direct address, linear AR updates and circular step setup.
`timescale 1ns / 1ps
module aag_decode import aag_pkg::*; (
  input  aag_in_t      item_i,
  input  logic [15:0]  ar_i,
  input  logic [15:0]  ar0_i,
  input  logic         bitrev_en_i,
  output aag_dec_t     dec_o
);

  function automatic logic [15:0] bit_rev(input logic [15:0] v);
    logic [15:0] r;
    for (int i = 0; i < 16; i++) begin
      r[i] = v[15 - i];
    end
    return r;
  endfunction

  logic [15:0] unit;
  logic [3:0]  mode;
  logic [15:0] step;
  logic        circ_req;
  logic [15:0] rc_sum;
  logic [15:0] rc_dif;
  aag_dec_t    dec;

  assign rc_sum = bit_rev(bit_rev(ar_i) + bit_rev(ar0_i));
  assign rc_dif = bit_rev(bit_rev(ar_i) - bit_rev(ar0_i));

  always_comb begin
    unit     = (item_i.kind == KIND_LONG) ? 16'd2 : 16'd1;
    mode     = item_i.opcode_low[6:3];
    step     = '0;
    circ_req = 1'b0;
    dec          = '0;
    dec.ar_idx   = ar_sel(item_i.kind, item_i.opcode_low);
    dec.lin_ar   = ar_i;
    dec.addr     = ar_i;
    case (item_i.kind)
      KIND_LOAD: begin
        dec.ar_idx = item_i.ar_index;
        dec.ar_we  = 1'b1;
        dec.lin_ar = item_i.ar_value;
        dec.addr   = '0;
      end
      KIND_XMEM: begin
        dec.indirect = 1'b1;
        dec.ar_we    = 1'b1;
        case (item_i.opcode_low[7:6])
          XMOD_NONE: dec.lin_ar = ar_i;
          XMOD_DEC:  dec.lin_ar = ar_i - 16'd1;
          XMOD_INC:  dec.lin_ar = ar_i + 16'd1;
          default: begin
            circ_req = 1'b1;
            step     = ar0_i;
          end
        endcase
      end
      default: begin
        if (!item_i.opcode_low[7]) begin
          if (item_i.cpl_mode) begin
            dec.addr = item_i.stack_ptr + {9'd0, item_i.opcode_low[6:0]};
          end else begin
            dec.addr = {item_i.dp_page, item_i.opcode_low[6:0]};
          end
        end else begin
          dec.indirect = 1'b1;
          dec.ar_we    = 1'b1;
          if (item_i.kind == KIND_SINGLE && item_i.compat_mode) begin
            dec.arp_write = 1'b1;
            dec.arp_value = item_i.opcode_low[2:0];
          end
          case (mode)
            MODE_NONE:     dec.lin_ar = ar_i;
            MODE_POST_DEC: dec.lin_ar = ar_i - unit;
            MODE_POST_INC: dec.lin_ar = ar_i + unit;
            MODE_PRE_INC: begin
              dec.lin_ar   = ar_i + unit;
              dec.addr_new = 1'b1;
            end
            MODE_RC_SUB:   dec.lin_ar = bitrev_en_i ? rc_dif : ar_i - ar0_i;
            MODE_SUB_AR0:  dec.lin_ar = ar_i - ar0_i;
            MODE_ADD_AR0:  dec.lin_ar = ar_i + ar0_i;
            MODE_RC_ADD:   dec.lin_ar = bitrev_en_i ? rc_sum : ar_i + ar0_i;
            MODE_CIRC_DEC: begin
              circ_req = 1'b1;
              step     = 16'(~unit + 16'd1);
            end
            MODE_CIRC_SUB: begin
              circ_req = 1'b1;
              step     = 16'(~ar0_i + 16'd1);
            end
            MODE_CIRC_INC: begin
              circ_req = 1'b1;
              step     = unit;
            end
            MODE_CIRC_ADD: begin
              circ_req = 1'b1;
              step     = ar0_i;
            end
            MODE_IMM_OFS: begin
              dec.addr          = ar_i + item_i.long_imm;
              dec.used_long_imm = 1'b1;
            end
            MODE_IMM_PRE: begin
              dec.lin_ar        = ar_i + item_i.long_imm;
              dec.addr_new      = 1'b1;
              dec.used_long_imm = 1'b1;
            end
            MODE_IMM_CIRC: begin
              circ_req          = 1'b1;
              step              = item_i.long_imm;
              dec.addr_new      = 1'b1;
              dec.used_long_imm = 1'b1;
            end
            default: begin
              dec.addr          = item_i.long_imm;
              dec.used_long_imm = 1'b1;
            end
          endcase
        end
      end
    endcase
    if (circ_req) begin
      if (item_i.circ_size == '0) begin
        dec.lin_ar = ar_i + step;
      end else begin
        dec.circ     = 1'b1;
        dec.step_neg = step[15];
        dec.step_mag = step[15] ? 16'(~step + 16'd1) : step;
      end
    end
    dec_o = dec;
  end

endmodule

// ----- hw/rtl/aux_address_generator.sv -----
// Top level: aux register file, sequencer and result register.
//
// channel  | valid       | ready       | payload
// ---------+-------------+-------------+--------------------
// in       | in_valid_i  | in_ready_o  | in_data_i  (aag_in_t)
// out      | out_valid_o | out_ready_i | out_data_o (aag_out_t)
// cfg      | cfg_valid_i | cfg_ready_o | cfg_data_i (bitrev_enable)
//
// Direct, load and linear indirect items go from S_IDLE straight to S_DONE.
// Circular items with a nonzero buffer size make two passes of the shared
// remainder unit (AR mod size, step mod size), then a combine step.
// in_ready_o is low while an item is in flight; the sequencer holds in S_DONE
// while the result register still holds a result not yet taken by out_ready_i.
// Reset clears all aux registers and sets bitrev_enable to 1.
`timescale 1ns / 1ps
module aux_address_generator import aag_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  aag_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output aag_out_t out_data_o,
  input  logic     cfg_valid_i,
  output logic     cfg_ready_o,
  input  logic     cfg_data_i
);

  aag_state_e        state_q, state_d;
  logic              bitrev_q;
  logic [7:0][15:0]  aux_q;
  aag_dec_t          dec, dec_q;
  logic [2:0]        rd_idx;
  logic [15:0]       ar_q, bk_q, idx_q, base_q, m_q, t_q;
  logic [16:0]       sum;
  logic [15:0]       final_ar;
  logic              out_valid_q;
  aag_out_t          out_q;
  logic              rem_start, rem_busy, rem_done;
  logic [15:0]       rem_dividend, rem_val;
  logic              in_fire, out_load;

  assign rd_idx = ar_sel(in_data_i.kind, in_data_i.opcode_low);

  aag_decode u_decode (
    .item_i      (in_data_i),
    .ar_i        (aux_q[rd_idx]),
    .ar0_i       (aux_q[0]),
    .bitrev_en_i (bitrev_q),
    .dec_o       (dec)
  );

  assign rem_dividend = (state_q == S_REM_AR) ? ar_q : dec_q.step_mag;

  aag_rem_unit u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (rem_start),
    .dividend_i (rem_dividend),
    .divisor_i  (bk_q),
    .busy_o     (rem_busy),
    .done_o     (rem_done),
    .rem_o      (rem_val)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:      if (in_valid_i) state_d = dec.circ ? S_REM_AR : S_DONE;
      S_REM_AR:    state_d = S_WAIT_AR;
      S_WAIT_AR:   if (rem_done) state_d = S_REM_STEP;
      S_REM_STEP:  state_d = S_WAIT_STEP;
      S_WAIT_STEP: if (rem_done) state_d = S_COMBINE;
      S_COMBINE:   state_d = S_DONE;
      S_DONE:      if (out_load) state_d = S_IDLE;
      default:     state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = (state_q == S_IDLE);
    rem_start  = (state_q == S_REM_AR) || (state_q == S_REM_STEP);
    out_load   = (state_q == S_DONE) && (!out_valid_q || out_ready_i);
  end

  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign sum         = {1'b0, idx_q} + {1'b0, m_q};
  assign final_ar    = dec_q.circ ? base_q + t_q : dec_q.lin_ar;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      bitrev_q    <= 1'b1;
      aux_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        bitrev_q <= cfg_data_i;
      end
      if (out_load && dec_q.ar_we) begin
        aux_q[dec_q.ar_idx] <= final_ar;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      dec_q <= dec;
      ar_q  <= aux_q[rd_idx];
      bk_q  <= in_data_i.circ_size;
    end
    if (state_q == S_WAIT_AR && rem_done) begin
      idx_q  <= rem_val;
      base_q <= ar_q - rem_val;
    end
    if (state_q == S_WAIT_STEP && rem_done) begin
      m_q <= (dec_q.step_neg && rem_val != '0) ? bk_q - rem_val : rem_val;
    end
    if (state_q == S_COMBINE) begin
      t_q <= (sum >= {1'b0, bk_q}) ? 16'(sum - {1'b0, bk_q}) : sum[15:0];
    end
    if (out_load) begin
      out_q.address       <= dec_q.addr_new ? final_ar : dec_q.addr;
      out_q.indirect      <= dec_q.indirect;
      out_q.used_long_imm <= dec_q.used_long_imm;
      out_q.arp_write     <= dec_q.arp_write;
      out_q.arp_value     <= dec_q.arp_value;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_rem_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_start |-> !rem_busy)
    else $error("remainder unit restarted while busy");

  a_rem_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_done |-> (state_q == S_WAIT_AR || state_q == S_WAIT_STEP))
    else $error("remainder done outside a wait state");

  a_aux_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_DONE) |=> $stable(aux_q))
    else $error("aux register changed outside result write");

  a_circ_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_COMBINE) |-> (idx_q < bk_q && m_q < bk_q))
    else $error("circular index out of buffer range");

endmodule

// ----- dv/aux_address_generator_tb.sv -----
// Self-checking testbench for aux_address_generator: directed table, then random beats.
`timescale 1ns / 1ps
module aux_address_generator_tb;
  import aag_pkg::*;

  typedef struct {
    aag_in_t  item;
    bit       typed;
    aag_out_t want;
  } script_row_t;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_PERIODIC, RX_SPARSE} rx_mode_e;

  localparam int PHASES       = 4;
  localparam int PHASE_ITEMS  = 325;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  aag_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  aag_out_t out_data;
  logic     cfg_valid = 1'b0;
  logic     cfg_ready;
  logic     cfg_data = 1'b0;

  logic [15:0] ar_file [8] = '{default: 16'h0000};
  logic        rc_enable = 1'b1;
  aag_out_t    pending_results [$];
  int          mismatches = 0;
  int          burst_left = 0;
  int unsigned rx_tick = 0;
  rx_mode_e    rx_mode = RX_OPEN;

  aux_address_generator DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  always #4 clk = ~clk;

  initial begin
    #4_000_000;
    $display("FAIL");
    $finish;
  end

  function automatic logic [15:0] bitrev16(input logic [15:0] v);
    logic [15:0] r;
    for (int i = 0; i < 16; i++) r[i] = v[15-i];
    return r;
  endfunction

  function automatic logic [15:0] rc_step(input logic [15:0] a, input logic [15:0] b,
                                          input bit sub);
    logic [15:0] ra, rb, s;
    ra = bitrev16(a);
    rb = bitrev16(b);
    s  = sub ? ra - rb : ra + rb;
    return bitrev16(s);
  endfunction

  // step is signed 16-bit; size 0 means a plain add
  function automatic logic [15:0] circ_add(input logic [15:0] ar, input logic [15:0] step,
                                           input logic [15:0] bk);
    int unsigned span, mag, idx, base, m, t;
    if (bk == 16'd0) return ar + step;
    span = bk;
    mag  = step[15] ? 32'h10000 - step : step;
    idx  = ar % span;
    base = ar - idx;
    m    = mag % span;
    if (step[15]) m = (span - m) % span;
    t = idx + m;
    if (t >= span) t -= span;
    return 16'(base + t);
  endfunction

  function automatic aag_out_t resolve_operand(input aag_in_t it);
    aag_out_t    res;
    logic [2:0]  r;
    logic [15:0] ar, a0, unit, bk, limm;
    res  = '0;
    bk   = it.circ_size;
    limm = it.long_imm;
    a0   = ar_file[0];
    if (it.kind == KIND_LOAD) begin
      ar_file[it.ar_index] = it.ar_value;
    end else if (it.kind == KIND_XMEM) begin
      r = {1'b0, it.opcode_low[5:4]} + XMEM_AR_BASE;
      ar = ar_file[r];
      res.address  = ar;
      res.indirect = 1'b1;
      case (it.opcode_low[7:6])
        XMOD_DEC:  ar_file[r] = ar - 16'd1;
        XMOD_INC:  ar_file[r] = ar + 16'd1;
        XMOD_CIRC: ar_file[r] = circ_add(ar, a0, bk);
        default: ;
      endcase
    end else if (!it.opcode_low[7]) begin
      res.address = it.cpl_mode ? it.stack_ptr + {9'd0, it.opcode_low[6:0]}
                                : {it.dp_page, it.opcode_low[6:0]};
    end else begin
      r    = it.opcode_low[2:0];
      ar   = ar_file[r];
      unit = (it.kind == KIND_LONG) ? 16'd2 : 16'd1;
      res.address  = ar;
      res.indirect = 1'b1;
      case (it.opcode_low[6:3])
        MODE_NONE:     ;
        MODE_POST_DEC: ar = ar - unit;
        MODE_POST_INC: ar = ar + unit;
        MODE_PRE_INC: begin
          ar = ar + unit;
          res.address = ar;
        end
        MODE_RC_SUB:   ar = rc_enable ? rc_step(ar, a0, 1'b1) : ar - a0;
        MODE_SUB_AR0:  ar = ar - a0;
        MODE_ADD_AR0:  ar = ar + a0;
        MODE_RC_ADD:   ar = rc_enable ? rc_step(ar, a0, 1'b0) : ar + a0;
        MODE_CIRC_DEC: ar = circ_add(ar, 16'd0 - unit, bk);
        MODE_CIRC_SUB: ar = circ_add(ar, 16'd0 - a0, bk);
        MODE_CIRC_INC: ar = circ_add(ar, unit, bk);
        MODE_CIRC_ADD: ar = circ_add(ar, a0, bk);
        MODE_IMM_OFS: begin
          res.address = ar + limm;
          res.used_long_imm = 1'b1;
        end
        MODE_IMM_PRE: begin
          ar = ar + limm;
          res.address = ar;
          res.used_long_imm = 1'b1;
        end
        MODE_IMM_CIRC: begin
          ar = circ_add(ar, limm, bk);
          res.address = ar;
          res.used_long_imm = 1'b1;
        end
        default: begin
          res.address = limm;
          res.used_long_imm = 1'b1;
        end
      endcase
      ar_file[r] = ar;
      if (it.kind == KIND_SINGLE && it.compat_mode) begin
        res.arp_write = 1'b1;
        res.arp_value = r;
      end
    end
    return res;
  endfunction

  function automatic logic [15:0] pick_word();
    case ($urandom_range(0, 5))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'h8000;
      3:       return 16'($urandom_range(0, 31));
      4:       return 16'h7FFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_size();
    int unsigned roll;
    roll = $urandom_range(0, 19);
    if (roll < 4) return 16'h0000;
    if (roll < 12) return 16'($urandom_range(1, 16));
    if (roll == 12) return 16'h0001;
    if (roll == 13) return 16'hFFFF;
    if (roll == 14) return 16'd1 << $urandom_range(0, 15);
    return 16'($urandom);
  endfunction

  function automatic aag_in_t random_item();
    aag_in_t     it;
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 15) it.kind = KIND_LOAD;
    else if (roll < 27) it.kind = KIND_XMEM;
    else if (roll < 40) it.kind = KIND_LONG;
    else it.kind = KIND_SINGLE;
    it.opcode_low = 8'($urandom);
    if ((it.kind == KIND_SINGLE || it.kind == KIND_LONG) && $urandom_range(0, 9) != 0)
      it.opcode_low[7] = 1'b1;
    it.long_imm    = pick_word();
    it.dp_page     = 9'($urandom);
    it.stack_ptr   = pick_word();
    it.cpl_mode    = 1'($urandom);
    it.compat_mode = 1'($urandom);
    it.circ_size   = pick_size();
    it.ar_index    = 3'($urandom);
    it.ar_value    = pick_word();
    return it;
  endfunction

  task automatic send_item(input aag_in_t it, input bit typed, input aag_out_t want);
    aag_out_t predicted;
    in_data  <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = resolve_operand(it);
    pending_results.push_back(typed ? want : predicted);
  endtask

  task automatic pace();
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_bitrev(input logic value);
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    rc_enable = value;
  endtask

  always @(posedge clk) begin
    rx_tick <= rx_tick + 1;
    if (rx_tick % 256 == 0) rx_mode <= rx_mode_e'($urandom_range(0, 3));
    case (rx_mode)
      RX_OPEN:     out_ready <= 1'b1;
      RX_COIN:     out_ready <= 1'($urandom);
      RX_PERIODIC: out_ready <= (rx_tick % 5 == 0);
      default:     out_ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  always @(posedge clk) begin
    aag_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result beat with nothing pending: %p", out_data);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (want.address !== out_data.address) begin
          $error("address: expected %h, got %h", want.address, out_data.address);
          mismatches++;
        end
        if (want.indirect !== out_data.indirect) begin
          $error("indirect: expected %b, got %b", want.indirect, out_data.indirect);
          mismatches++;
        end
        if (want.used_long_imm !== out_data.used_long_imm) begin
          $error("used_long_imm: expected %b, got %b", want.used_long_imm,
                 out_data.used_long_imm);
          mismatches++;
        end
        if (want.arp_write !== out_data.arp_write) begin
          $error("arp_write: expected %b, got %b", want.arp_write, out_data.arp_write);
          mismatches++;
        end
        if (want.arp_value !== out_data.arp_value) begin
          $error("arp_value: expected %0d, got %0d", want.arp_value, out_data.arp_value);
          mismatches++;
        end
      end
    end
  end

  initial begin
    script_row_t script [$];
    // kind, opcode, long_imm, dp_page, stack_ptr, cpl, compat, circ_size, ar_index, ar_value
    script.push_back(script_row_t'{aag_in_t'{KIND_SINGLE, {1'b0, 7'h7F}, 16'h0, 9'h1FF, 16'h0,
      1'b0, 1'b0, 16'h0, 3'd0, 16'h0}, 1'b1, aag_out_t'{16'hFFFF, 1'b0, 1'b0, 1'b0, 3'd0}});
    script.push_back(script_row_t'{aag_in_t'{KIND_SINGLE, {1'b0, 7'h7F}, 16'h0, 9'h0, 16'hFFFF,
      1'b1, 1'b0, 16'h0, 3'd0, 16'h0}, 1'b1, aag_out_t'{16'h007E, 1'b0, 1'b0, 1'b0, 3'd0}});
    script.push_back(script_row_t'{aag_in_t'{KIND_LONG, 8'h00, 16'h0, 9'h0, 16'h0,
      1'b0, 1'b1, 16'h0, 3'd0, 16'h0}, 1'b1, aag_out_t'{16'h0000, 1'b0, 1'b0, 1'b0, 3'd0}});
    script.push_back(script_row_t'{aag_in_t'{KIND_LOAD, 8'hFF, 16'hFFFF, 9'h1FF, 16'hFFFF,
      1'b1, 1'b1, 16'hFFFF, 3'd0, 16'h0008}, 1'b1, aag_out_t'('0)});
    script.push_back(script_row_t'{aag_in_t'{KIND_LOAD, 8'h00, 16'h0, 9'h0, 16'h0,
      1'b0, 1'b0, 16'h0, 3'd1, 16'h1000}, 1'b1, aag_out_t'('0)});
    script.push_back(script_row_t'{aag_in_t'{KIND_LOAD, 8'h00, 16'h0, 9'h0, 16'h0,
      1'b0, 1'b0, 16'h0, 3'd7, 16'hFFFF}, 1'b1, aag_out_t'('0)});
    script.push_back(script_row_t'{aag_in_t'{KIND_SINGLE, {1'b1, MODE_NONE, 3'd1}, 16'h0, 9'h0,
      16'h0, 1'b0, 1'b1, 16'h0, 3'd0, 16'h0}, 1'b1,
      aag_out_t'{16'h1000, 1'b1, 1'b0, 1'b1, 3'd1}});
    script.push_back(script_row_t'{aag_in_t'{KIND_SINGLE, {1'b1, MODE_POST_DEC, 3'd1}, 16'h0,
      9'h0, 16'h0, 1'b0, 1'b0, 16'h0, 3'd0, 16'h0}, 1'b1,
      aag_out_t'{16'h1000, 1'b1, 1'b0, 1'b0, 3'd0}});
    script.push_back(script_row_t'{aag_in_t'{KIND_LONG, {1'b1, MODE_POST_INC, 3'd1}, 16'h0,
      9'h0, 16'h0, 1'b0, 1'b1, 16'h0, 3'd0, 16'h0}, 1'b0, aag_out_t'('0)});
    script.push_back(script_row_t'{aag_in_t'{KIND_SINGLE, {1'b1, MODE_PRE_INC, 3'd7}, 16'h0,
      9'h0, 16'h0, 1'b0, 1'b0, 16'h0, 3'd0, 16'h0}, 1'b0, aag_out_t'('0)});
    script.push_back(script_row_t'{aag_in_t'{KIND_SINGLE, {1'b1, MODE_RC_SUB, 3'd1}, 16'h0,
      9'h0, 16'h0, 1'b0, 1'b0, 16'h0, 3'd0, 16'h0}, 1'b0, aag_out_t'('0)});
    script.push_back(script_row_t'{aag_in_t'{KIND_SINGLE, {1'b1, MODE_SUB_AR0, 3'd1}, 16'h0,
      9'h0, 16'h0, 1'b0, 1'b0, 16'h0, 3'd0, 16'h0}, 1'b0, aag_out_t'('0)});
    script.push_back(script_row_t'{aag_in_t'{KIND_LONG, {1'b1, MODE_ADD_AR0, 3'd1}, 16'h0,
      9'h0, 16'h0, 1'b0, 1'b0, 16'h0, 3'd0, 16'h0}, 1'b0, aag_out_t'('0)});
    script.push_back(script_row_t'{aag_in_t'{KIND_SINGLE, {1'b1, MODE_RC_ADD, 3'd1}, 16'h0,
      9'h0, 16'h0, 1'b0, 1'b0, 16'h0, 3'd0, 16'h0}, 1'b0, aag_out_t'('0)});
    // circular size 0 falls back to a linear step
    script.push_back(script_row_t'{aag_in_t'{KIND_SINGLE, {1'b1, MODE_CIRC_DEC, 3'd1}, 16'h0,
      9'h0, 16'h0, 1'b0, 1'b0, 16'h0, 3'd0, 16'h0}, 1'b0, aag_out_t'('0)});
    script.push_back(script_row_t'{aag_in_t'{KIND_LONG, {1'b1, MODE_CIRC_DEC, 3'd1}, 16'h0,
      9'h0, 16'h0, 1'b0, 1'b0, 16'd5, 3'd0, 16'h0}, 1'b0, aag_out_t'('0)});
    script.push_back(script_row_t'{aag_in_t'{KIND_SINGLE, {1'b1, MODE_CIRC_SUB, 3'd1}, 16'h0,
      9'h0, 16'h0, 1'b0, 1'b0, 16'd16, 3'd0, 16'h0}, 1'b0, aag_out_t'('0)});
    script.push_back(script_row_t'{aag_in_t'{KIND_LONG, {1'b1, MODE_CIRC_INC, 3'd7}, 16'h0,
      9'h0, 16'h0, 1'b0, 1'b0, 16'hFFFF, 3'd0, 16'h0}, 1'b0, aag_out_t'('0)});
    script.push_back(script_row_t'{aag_in_t'{KIND_SINGLE, {1'b1, MODE_CIRC_ADD, 3'd1}, 16'h0,
      9'h0, 16'h0, 1'b0, 1'b0, 16'd3, 3'd0, 16'h0}, 1'b0, aag_out_t'('0)});
    script.push_back(script_row_t'{aag_in_t'{KIND_SINGLE, {1'b1, MODE_IMM_OFS, 3'd1}, 16'hFFFF,
      9'h0, 16'h0, 1'b0, 1'b0, 16'h0, 3'd0, 16'h0}, 1'b0, aag_out_t'('0)});
    script.push_back(script_row_t'{aag_in_t'{KIND_LONG, {1'b1, MODE_IMM_PRE, 3'd1}, 16'h1234,
      9'h0, 16'h0, 1'b0, 1'b0, 16'h0, 3'd0, 16'h0}, 1'b0, aag_out_t'('0)});
    script.push_back(script_row_t'{aag_in_t'{KIND_SINGLE, {1'b1, MODE_IMM_CIRC, 3'd1}, 16'h8000,
      9'h0, 16'h0, 1'b0, 1'b0, 16'd7, 3'd0, 16'h0}, 1'b0, aag_out_t'('0)});
    script.push_back(script_row_t'{aag_in_t'{KIND_SINGLE, {1'b1, MODE_ABS, 3'd1}, 16'hABCD,
      9'h0, 16'h0, 1'b0, 1'b1, 16'h0, 3'd0, 16'h0}, 1'b1,
      aag_out_t'{16'hABCD, 1'b1, 1'b1, 1'b1, 3'd1}});
    // long words never touch ARP
    script.push_back(script_row_t'{aag_in_t'{KIND_LONG, {1'b1, MODE_ABS, 3'd7}, 16'h0000,
      9'h0, 16'h0, 1'b0, 1'b1, 16'h0, 3'd0, 16'h0}, 1'b1,
      aag_out_t'{16'h0000, 1'b1, 1'b1, 1'b0, 3'd0}});
    script.push_back(script_row_t'{aag_in_t'{KIND_XMEM, {XMOD_NONE, 2'd0, 4'h0}, 16'h0,
      9'h0, 16'h0, 1'b0, 1'b0, 16'h0, 3'd0, 16'h0}, 1'b0, aag_out_t'('0)});
    script.push_back(script_row_t'{aag_in_t'{KIND_XMEM, {XMOD_DEC, 2'd1, 4'hF}, 16'h0,
      9'h0, 16'h0, 1'b0, 1'b0, 16'h0, 3'd0, 16'h0}, 1'b0, aag_out_t'('0)});
    script.push_back(script_row_t'{aag_in_t'{KIND_XMEM, {XMOD_INC, 2'd2, 4'h0}, 16'h0,
      9'h0, 16'h0, 1'b0, 1'b0, 16'h0, 3'd0, 16'h0}, 1'b0, aag_out_t'('0)});
    script.push_back(script_row_t'{aag_in_t'{KIND_XMEM, {XMOD_CIRC, 2'd3, 4'hF}, 16'h0,
      9'h0, 16'h0, 1'b0, 1'b1, 16'd10, 3'd0, 16'h0}, 1'b0, aag_out_t'('0)});

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (script[i]) begin
      pace();
      send_item(script[i].item, script[i].typed, script[i].want);
    end
    drain();

    for (int phase = 0; phase < PHASES; phase++) begin
      write_bitrev(phase[0]);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pace();
        send_item(random_item(), 1'b0, '0);
      end
      drain();
    end

    repeat (50) @(posedge clk);
    if (mismatches == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
